### design/wrrd_pkg.sv
package wrrd_pkg;

  localparam int unsigned HostsMax  = 16;
  localparam int unsigned LevelsMax = 8;

  localparam int unsigned HostW     = 4;
  localparam int unsigned CapW      = 8;
  localparam int unsigned HostCntW  = 5;
  localparam int unsigned LvlCntW   = 4;
  localparam int unsigned LvlStartW = 32;
  localparam int unsigned PcW       = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_DISPATCH = 2'd0,
    MODE_HOST     = 2'd1,
    MODE_LEVEL    = 2'd2,
    MODE_RSVD     = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_TARGET = 2'd1,
    ST_NO_CAP     = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOST_COUNT  = 3'd0,
    CFG_CAP_LOW     = 3'd1,
    CFG_CAP_HIGH    = 3'd2,
    CFG_LEVEL_COUNT = 3'd3,
    CFG_LEVEL_START = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_BAD,
    OP_DISP,
    OP_HOST,
    OP_LEVEL,
    OP_PROBE,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_IN,
    C_IS_DISP,
    C_IS_HOST,
    C_IS_LEVEL,
    C_CNT_LT,
    C_HOST_BAD,
    C_LVL_BAD,
    C_NOT_DONE,
    C_OUT_BUSY
  } cond_e;

  typedef logic [PcW-1:0] pc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   jmp;
  } ucode_t;

  localparam pc_t PC_IDLE    = 4'd0;
  localparam pc_t PC_DEC_D   = 4'd1;
  localparam pc_t PC_DEC_H   = 4'd2;
  localparam pc_t PC_DEC_L   = 4'd3;
  localparam pc_t PC_BAD     = 4'd4;
  localparam pc_t PC_DISP    = 4'd5;
  localparam pc_t PC_DISP_GO = 4'd6;
  localparam pc_t PC_HOST    = 4'd7;
  localparam pc_t PC_HOST_GO = 4'd8;
  localparam pc_t PC_LEVEL   = 4'd9;
  localparam pc_t PC_PROBE   = 4'd10;
  localparam pc_t PC_EMIT    = 4'd11;
  localparam pc_t PC_WRAP    = 4'd12;

  // Control store: jump to jmp when cond holds, else fall through to the next step.
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t uw;
    unique case (pc)
      PC_IDLE:    uw = '{op: OP_LATCH, cond: C_NO_IN,    jmp: PC_IDLE};
      PC_DEC_D:   uw = '{op: OP_NOP,   cond: C_IS_DISP,  jmp: PC_DISP};
      PC_DEC_H:   uw = '{op: OP_NOP,   cond: C_IS_HOST,  jmp: PC_HOST};
      PC_DEC_L:   uw = '{op: OP_NOP,   cond: C_IS_LEVEL, jmp: PC_LEVEL};
      PC_BAD:     uw = '{op: OP_BAD,   cond: C_ALWAYS,   jmp: PC_EMIT};
      PC_DISP:    uw = '{op: OP_DISP,  cond: C_CNT_LT,   jmp: PC_EMIT};
      PC_DISP_GO: uw = '{op: OP_NOP,   cond: C_ALWAYS,   jmp: PC_PROBE};
      PC_HOST:    uw = '{op: OP_HOST,  cond: C_HOST_BAD, jmp: PC_EMIT};
      PC_HOST_GO: uw = '{op: OP_NOP,   cond: C_ALWAYS,   jmp: PC_PROBE};
      PC_LEVEL:   uw = '{op: OP_LEVEL, cond: C_LVL_BAD,  jmp: PC_EMIT};
      PC_PROBE:   uw = '{op: OP_PROBE, cond: C_NOT_DONE, jmp: PC_PROBE};
      PC_EMIT:    uw = '{op: OP_EMIT,  cond: C_OUT_BUSY, jmp: PC_EMIT};
      PC_WRAP:    uw = '{op: OP_NOP,   cond: C_ALWAYS,   jmp: PC_IDLE};
      default:    uw = '{op: OP_NOP,   cond: C_ALWAYS,   jmp: PC_IDLE};
    endcase
    return uw;
  endfunction

endpackage

### design/weighted_round_robin_dispatch_unit.sv
// A dispatch that stays on its host goes straight to its result. Requests that move the cursor
// run a skip loop that probes up to the host count of hosts, one host per cycle.
// A new input transaction is taken only once the previous one has reached the output register.
// A waiting result does not block the next input transaction.
// Reset (rst_ni low, asynchronous): cursor and grant count 0, host_count 1,
// capacity_low_hosts 1, other registers 0, output empty.
module weighted_round_robin_dispatch_unit #(
  parameter int unsigned MAX_HOSTS  = wrrd_pkg::HostsMax,
  parameter int unsigned MAX_LEVELS = wrrd_pkg::LevelsMax
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wrrd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wrrd_pkg::CfgDataW-1:0]  cfg_data_i,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [wrrd_pkg::InDataW-1:0]   s_axis_tdata,   // [3:0] target_index
  input  logic [wrrd_pkg::ModeW-1:0]     s_axis_tuser,   // [1:0] mode

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [wrrd_pkg::OutDataW-1:0]  m_axis_tdata    // [3:0] served_host,
                                                         // [7:4] cursor_after, [9:8] status
);

  import wrrd_pkg::*;

  logic [HostCntW-1:0]  host_count_q;
  logic [CfgDataW-1:0]  cap_low_q;
  logic [CfgDataW-1:0]  cap_high_q;
  logic [LvlCntW-1:0]   level_count_q;
  logic [LvlStartW-1:0] level_starts_q;

  pc_t                  pc_q, pc_d;
  mode_e                mode_q, mode_d;
  logic [HostW-1:0]     target_q, target_d;
  logic [HostW-1:0]     cursor_q, cursor_d;
  logic [HostW-1:0]     served_q, served_d;
  logic [HostW-1:0]     start_q, start_d;
  logic [HostW-1:0]     probe_q, probe_d;
  logic [HostW-1:0]     iter_q, iter_d;
  logic [CapW-1:0]      grants_q, grants_d;
  status_e              status_q, status_d;

  logic                 out_valid_q, out_valid_d;
  logic [HostW-1:0]     out_served_q, out_served_d;
  logic [HostW-1:0]     out_cursor_q, out_cursor_d;
  status_e              out_status_q, out_status_d;

  ucode_t               uw;
  logic                 cond_true;
  logic [HostCntW-1:0]  n_hosts;
  logic [LvlCntW-1:0]   n_levels;
  logic [2*CfgDataW-1:0] cap_vec;
  logic [CapW-1:0]      cnt;
  logic                 cnt_lt;
  logic                 host_bad;
  logic [HostW-1:0]     lvl_start;
  logic                 lvl_bad;
  logic                 probe_hit;
  logic                 probe_last;
  logic                 out_free;
  logic [HostW-1:0]     cursor_norm;

  function automatic logic [HostW-1:0] next_host(logic [HostW-1:0] h, logic [HostCntW-1:0] n);
    return (({1'b0, h} + 5'd1) == n) ? '0 : h + 4'd1;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (pc_q == PC_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_status_q, out_cursor_q, out_served_q};

  always_comb begin
    if (host_count_q == '0) begin
      n_hosts = 5'd1;
    end else if (host_count_q > HostCntW'(MAX_HOSTS)) begin
      n_hosts = HostCntW'(MAX_HOSTS);
    end else begin
      n_hosts = host_count_q;
    end
    n_levels = (level_count_q > LvlCntW'(MAX_LEVELS)) ? LvlCntW'(MAX_LEVELS) : level_count_q;
  end

  assign cap_vec     = {cap_high_q, cap_low_q};
  assign cnt         = grants_q + 8'd1;
  assign cnt_lt      = cnt < cap_vec[cursor_q*CapW +: CapW];
  assign host_bad    = {1'b0, target_q} >= n_hosts;
  assign lvl_start   = level_starts_q[target_q[2:0]*HostW +: HostW];
  assign lvl_bad     = (target_q >= n_levels) || ({1'b0, lvl_start} >= n_hosts);
  assign probe_hit   = cap_vec[probe_q*CapW +: CapW] != '0;
  assign probe_last  = {1'b0, iter_q} == (n_hosts - 5'd1);
  assign out_free    = !out_valid_q || m_axis_tready;
  assign cursor_norm = ({1'b0, cursor_q} >= n_hosts) ? '0 : cursor_q;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_IN:    cond_true = !s_axis_tvalid;
      C_IS_DISP:  cond_true = (mode_q == MODE_DISPATCH);
      C_IS_HOST:  cond_true = (mode_q == MODE_HOST);
      C_IS_LEVEL: cond_true = (mode_q == MODE_LEVEL);
      C_CNT_LT:   cond_true = cnt_lt;
      C_HOST_BAD: cond_true = host_bad;
      C_LVL_BAD:  cond_true = lvl_bad;
      C_NOT_DONE: cond_true = !probe_hit && !probe_last;
      C_OUT_BUSY: cond_true = !out_free;
      default:    cond_true = 1'b1;
    endcase
    pc_d = cond_true ? uw.jmp : pc_q + 4'd1;
  end

  always_comb begin
    mode_d       = mode_q;
    target_d     = target_q;
    cursor_d     = cursor_q;
    served_d     = served_q;
    start_d      = start_q;
    probe_d      = probe_q;
    iter_d       = iter_q;
    grants_d     = grants_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_served_d = out_served_q;
    out_cursor_d = out_cursor_q;
    out_status_d = out_status_q;

    unique case (uw.op)
      OP_NOP: begin
      end
      OP_LATCH: begin
        cursor_d = cursor_norm;
        served_d = cursor_norm;
        status_d = ST_OK;
        if (s_axis_tvalid) begin
          mode_d   = mode_e'(s_axis_tuser);
          target_d = s_axis_tdata[HostW-1:0];
        end
      end
      OP_BAD: begin
        status_d = ST_BAD_TARGET;
      end
      OP_DISP: begin
        if (cnt_lt) begin
          grants_d = cnt;
        end else begin
          grants_d = '0;
          start_d  = next_host(cursor_q, n_hosts);
          probe_d  = next_host(cursor_q, n_hosts);
          iter_d   = '0;
        end
      end
      OP_HOST: begin
        if (host_bad) begin
          status_d = ST_BAD_TARGET;
        end else begin
          grants_d = '0;
          start_d  = target_q;
          probe_d  = target_q;
          iter_d   = '0;
        end
      end
      OP_LEVEL: begin
        if (lvl_bad) begin
          status_d = ST_BAD_TARGET;
        end else begin
          grants_d = '0;
          start_d  = lvl_start;
          probe_d  = lvl_start;
          iter_d   = '0;
        end
      end
      OP_PROBE: begin
        if (probe_hit) begin
          cursor_d = probe_q;
        end else if (probe_last) begin
          cursor_d = start_q;
          status_d = ST_NO_CAP;
        end else begin
          probe_d = next_host(probe_q, n_hosts);
          iter_d  = iter_q + 4'd1;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_served_d = (mode_q == MODE_DISPATCH) ? served_q : cursor_q;
          out_cursor_d = cursor_q;
          out_status_d = status_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_count_q   <= 5'd1;
      cap_low_q      <= 64'd1;
      cap_high_q     <= '0;
      level_count_q  <= '0;
      level_starts_q <= '0;
      pc_q           <= PC_IDLE;
      mode_q         <= MODE_DISPATCH;
      target_q       <= '0;
      cursor_q       <= '0;
      served_q       <= '0;
      start_q        <= '0;
      probe_q        <= '0;
      iter_q         <= '0;
      grants_q       <= '0;
      status_q       <= ST_OK;
      out_valid_q    <= 1'b0;
      out_served_q   <= '0;
      out_cursor_q   <= '0;
      out_status_q   <= ST_OK;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_HOST_COUNT:  host_count_q   <= cfg_data_i[HostCntW-1:0];
          CFG_CAP_LOW:     cap_low_q      <= cfg_data_i;
          CFG_CAP_HIGH:    cap_high_q     <= cfg_data_i;
          CFG_LEVEL_COUNT: level_count_q  <= cfg_data_i[LvlCntW-1:0];
          CFG_LEVEL_START: level_starts_q <= cfg_data_i[LvlStartW-1:0];
          default: begin
          end
        endcase
      end
      pc_q         <= pc_d;
      mode_q       <= mode_d;
      target_q     <= target_d;
      cursor_q     <= cursor_d;
      served_q     <= served_d;
      start_q      <= start_d;
      probe_q      <= probe_d;
      iter_q       <= iter_d;
      grants_q     <= grants_d;
      status_q     <= status_d;
      out_valid_q  <= out_valid_d;
      out_served_q <= out_served_d;
      out_cursor_q <= out_cursor_d;
      out_status_q <= out_status_d;
    end
  end

endmodule

### bench/weighted_round_robin_dispatch_unit_tb.sv
`timescale 1ns / 1ps

module weighted_round_robin_dispatch_unit_tb;
  import wrrd_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 30;
  localparam int unsigned RandPhases    = 8;
  localparam int unsigned ItemsPerPhase = 104;
  localparam int unsigned MaxPrinted    = 200;

  typedef struct {
    mode_e            mode;
    logic [HostW-1:0] target;
  } wrr_req_t;

  typedef struct packed {
    status_e          status;
    logic [HostW-1:0] cursor;
    logic [HostW-1:0] served;
  } grant_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [ModeW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // shadow of the block's registers and state
  logic [HostCntW-1:0] hosts_reg;
  logic [63:0]         cap_lo_reg;
  logic [63:0]         cap_hi_reg;
  logic [LvlCntW-1:0]  levels_reg;
  logic [31:0]         starts_reg;
  logic [HostW-1:0]    cur_host;
  logic [CapW-1:0]     grant_cnt;

  wrr_req_t      dispatch_req_q[$];
  grant_result_t grant_expect_q[$];

  int err_cnt        = 0;
  int cycle_cnt      = 0;
  int src_gap        = 0;
  int sink_stall     = 0;
  int hold_req       = 0;
  int hold_taken     = 0;
  int sink_hold_left = 0;
  bit src_steady     = 1'b0;
  bit sink_steady    = 1'b0;

  weighted_round_robin_dispatch_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [3:0] target_index
    .s_axis_tuser (s_axis_tuser),   // [1:0] mode
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // [3:0] served_host, [7:4] cursor_after, [9:8] status
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned host_span();
    int unsigned n;
    n = 32'(hosts_reg);
    if (n == 0) n = 1;
    if (n > HostsMax) n = HostsMax;
    return n;
  endfunction

  function automatic int unsigned level_span();
    int unsigned n;
    n = 32'(levels_reg);
    if (n > LevelsMax) n = LevelsMax;
    return n;
  endfunction

  function automatic logic [CapW-1:0] host_cap(int unsigned h);
    if (h < 8) return cap_lo_reg[h*8 +: 8];
    return cap_hi_reg[(h-8)*8 +: 8];
  endfunction

  // one pass over the rotation; cursor stays on start when nobody has capacity
  function automatic bit seek_capacity(int unsigned start, int unsigned n);
    int unsigned p;
    int unsigned i;
    p = start;
    for (i = 0; i < n; i++) begin
      if (host_cap(p) != 0) begin
        cur_host = p[HostW-1:0];
        return 1'b1;
      end
      p = (p + 1) % n;
    end
    cur_host = start[HostW-1:0];
    return 1'b0;
  endfunction

  function automatic grant_result_t predict_grant(mode_e mode, logic [HostW-1:0] target);
    grant_result_t    r;
    int unsigned      n;
    int unsigned      start;
    logic [CapW-1:0]  cnt;
    logic [HostW-1:0] served;
    bit               ok;
    n = host_span();
    if (32'(cur_host) >= n) cur_host = '0;
    served = cur_host;
    r.status = ST_OK;
    case (mode)
      MODE_DISPATCH: begin
        cnt = grant_cnt + 1'b1;
        if (cnt >= host_cap(32'(cur_host))) begin
          grant_cnt = '0;
          if (!seek_capacity((int'(cur_host) + 1) % n, n)) r.status = ST_NO_CAP;
        end else begin
          grant_cnt = cnt;
        end
      end
      MODE_HOST: begin
        if (32'(target) >= n) begin
          r.status = ST_BAD_TARGET;
        end else begin
          grant_cnt = '0;
          if (!seek_capacity(32'(target), n)) r.status = ST_NO_CAP;
        end
        served = cur_host;
      end
      MODE_LEVEL: begin
        start = 0;
        ok = 32'(target) < level_span();
        if (ok) begin
          start = 32'(starts_reg[target[2:0]*4 +: 4]);
          ok = start < n;
        end
        if (!ok) begin
          r.status = ST_BAD_TARGET;
        end else begin
          grant_cnt = '0;
          if (!seek_capacity(start, n)) r.status = ST_NO_CAP;
        end
        served = cur_host;
      end
      default: r.status = ST_BAD_TARGET;
    endcase
    r.served = served;
    r.cursor = cur_host;
    return r;
  endfunction

  function automatic void config_apply(cfg_idx_e idx, logic [63:0] v);
    case (idx)
      CFG_HOST_COUNT:  hosts_reg  = v[HostCntW-1:0];
      CFG_CAP_LOW:     cap_lo_reg = v;
      CFG_CAP_HIGH:    cap_hi_reg = v;
      CFG_LEVEL_COUNT: levels_reg = v[LvlCntW-1:0];
      CFG_LEVEL_START: starts_reg = v[31:0];
      default: ;
    endcase
  endfunction

  function automatic int idle_len(bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_caps(int style);
    logic [63:0] v;
    int          b;
    int          r;
    for (b = 0; b < 8; b++) begin
      r = $urandom_range(0, 99);
      case (style)
        1: v[b*8 +: 8] = 8'hFF;
        2: v[b*8 +: 8] = (r < 85) ? 8'd0 : 8'($urandom_range(1, 3));
        default: begin
          if (r < 30)      v[b*8 +: 8] = 8'd0;
          else if (r < 80) v[b*8 +: 8] = 8'($urandom_range(1, 4));
          else if (r < 95) v[b*8 +: 8] = 8'($urandom_range(5, 20));
          else             v[b*8 +: 8] = 8'($urandom_range(21, 255));
        end
      endcase
    end
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < MaxPrinted) $display("%0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic program_regs(input logic [63:0] hc, lo, hi, lc, ls);
    logic [63:0] vals [5];
    cfg_idx_e    idx;
    int          k;
    vals = '{hc, lo, hi, lc, ls};
    for (k = 0; k < 5; k++) begin
      idx = cfg_idx_e'(k);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      config_apply(idx, vals[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_req(mode_e m, int t);
    wrr_req_t q;
    q.mode   = m;
    q.target = t[HostW-1:0];
    dispatch_req_q.push_back(q);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (dispatch_req_q.size() != 0 || s_axis_tvalid || grant_expect_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_random_req();
    int          r;
    int unsigned n;
    n = host_span();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      push_req(MODE_DISPATCH, $urandom_range(0, 15));
    end else if (r < 82) begin
      push_req(MODE_HOST, $urandom_range(0, 1) ? $urandom_range(0, n - 1) : $urandom_range(0, 15));
    end else if (r < 94) begin
      push_req(MODE_LEVEL, $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 15));
    end else begin
      push_req(MODE_RSVD, $urandom_range(0, 15));
    end
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_requests
    wrr_req_t      req;
    grant_result_t res;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        res = predict_grant(mode_e'(s_axis_tuser), s_axis_tdata[HostW-1:0]);
        grant_expect_q.push_back(res);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (dispatch_req_q.size() != 0) begin
          req = dispatch_req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(InDataW-HostW){1'b0}}, req.target};
          s_axis_tuser  <= req.mode;
          src_gap = src_steady ? 0 : idle_len(1'b1);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink flow control
  always @(posedge clk_i) begin : check_results
    grant_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (grant_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction tdata=%h", m_axis_tdata));
        end else begin
          want = grant_expect_q.pop_front();
          if (m_axis_tdata[3:0] != want.served)
            report_mismatch($sformatf("served_host got %0d expected %0d",
                                      m_axis_tdata[3:0], want.served));
          if (m_axis_tdata[7:4] != want.cursor)
            report_mismatch($sformatf("cursor_after got %0d expected %0d",
                                      m_axis_tdata[7:4], want.cursor));
          if (m_axis_tdata[9:8] != want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      m_axis_tdata[9:8], want.status));
        end
      end
      if (sink_hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (sink_stall != 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 99) < 20) sink_stall = idle_len(1'b0);
      end
    end
  end

  // long sink hold-off so the block backs up into the request side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sink_hold_left <= 0;
    end else if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
    end else if (hold_req != hold_taken) begin
      sink_hold_left <= HoldCycles;
      hold_taken     <= hold_req;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("weighted_round_robin_dispatch_unit_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] hc_word;
    logic [63:0] lc_word;
    int          ph;
    int          i;
    int          style;
    hosts_reg  = 5'd1;
    cap_lo_reg = 64'd1;
    cap_hi_reg = '0;
    levels_reg = '0;
    starts_reg = '0;
    cur_host   = '0;
    grant_cnt  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out-of-reset settings: one host, no levels
    push_req(MODE_DISPATCH, 0);
    push_req(MODE_DISPATCH, 15);
    push_req(MODE_HOST, 0);
    push_req(MODE_HOST, 1);
    push_req(MODE_LEVEL, 0);
    push_req(MODE_RSVD, 15);
    wait_drained();

    // full rotation, zero-capacity holes, level count saturated
    program_regs(64'd16, 64'h0001_0300_FF01_0002, 64'h0100_0000_0500_0001,
                 64'd15, 64'h0000_0000_A8E1_7F30);
    push_req(MODE_DISPATCH, 0);
    push_req(MODE_DISPATCH, 0);
    push_req(MODE_DISPATCH, 0);
    push_req(MODE_HOST, 15);
    push_req(MODE_DISPATCH, 0);
    push_req(MODE_HOST, 1);
    push_req(MODE_LEVEL, 1);
    push_req(MODE_LEVEL, 2);
    push_req(MODE_LEVEL, 7);
    push_req(MODE_LEVEL, 8);
    push_req(MODE_LEVEL, 15);
    push_req(MODE_RSVD, 0);
    wait_drained();

    // no capacity anywhere, host count saturated
    program_regs(64'd31, 64'd0, 64'd0, 64'd15, 64'h0000_0000_A8E1_7F30);
    push_req(MODE_DISPATCH, 0);
    push_req(MODE_LEVEL, 0);
    push_req(MODE_HOST, 5);
    wait_drained();

    // host count zero acts as one host; cursor left on 5 gets pulled back
    program_regs(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
    push_req(MODE_DISPATCH, 0);
    push_req(MODE_DISPATCH, 0);
    wait_drained();

    for (ph = 0; ph < RandPhases; ph++) begin
      hc_word = {$urandom, $urandom};
      lc_word = {$urandom, $urandom};
      style   = 0;
      case (ph)
        0: hc_word[HostCntW-1:0] = 5'd16;
        1: hc_word[HostCntW-1:0] = 5'd1;
        2: begin
          hc_word[HostCntW-1:0] = 5'd16;
          style = 1;
        end
        3: hc_word[HostCntW-1:0] = 5'($urandom_range(17, 31));
        4: begin
          hc_word[HostCntW-1:0] = 5'($urandom_range(2, 16));
          style = 2;
        end
        default: hc_word[HostCntW-1:0] = 5'($urandom_range(0, 16));
      endcase
      if (ph == 0)      lc_word[LvlCntW-1:0] = 4'd8;
      else if (ph == 1) lc_word[LvlCntW-1:0] = 4'd0;
      src_steady  = (ph == 4);
      sink_steady = (ph == 4);
      program_regs(hc_word, rand_caps(style), rand_caps(style), lc_word, {$urandom, $urandom});
      for (i = 0; i < ItemsPerPhase; i++) push_random_req();
      if (ph == 5) hold_req++;
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("weighted_round_robin_dispatch_unit_tb: clean");
    end else begin
      $display("weighted_round_robin_dispatch_unit_tb: errors");
    end
    $finish;
  end

endmodule
